// ----- src/mocal_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mocal_pkg
// Shared types, register codes and the angle table for the magnetometer
// offset calibration and heading block.
// ----------------------------------------------------------------------------
package mocal_pkg;

    // number of rotation stages in the heading engine, 8 to 24
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;

    // datapath width of the rotation engine (16-bit reading scaled by 256
    // plus headroom for the rotation gain)
    localparam int CW = 27;

    // configuration port
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_OFFSET_X = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_OFFSET_Y = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_OFFSET_Z = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_GATE     = 3'd3;

    localparam logic [14:0] GATE_RESET = 15'd500;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef enum logic [1:0] {
        OP_MEASURE = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_CAL     = 2'd2,
        OP_FINISH  = 2'd3
    } op_t;

    // one queued item: corrected reading, or a marker for a non-measure op
    typedef struct packed {
        logic               meas;
        logic               sat;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // atan(2^-i) in 32-bit binary angle units
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] t;
        case (i)
            5'd0:    t = 32'h20000000;
            5'd1:    t = 32'h12E4051E;
            5'd2:    t = 32'h09FB385B;
            5'd3:    t = 32'h051111D4;
            5'd4:    t = 32'h028B0D43;
            5'd5:    t = 32'h0145D7E1;
            5'd6:    t = 32'h00A2F61E;
            5'd7:    t = 32'h00517C55;
            5'd8:    t = 32'h0028BE53;
            5'd9:    t = 32'h00145F2F;
            5'd10:   t = 32'h000A2F98;
            5'd11:   t = 32'h000517CC;
            5'd12:   t = 32'h00028BE6;
            5'd13:   t = 32'h000145F3;
            5'd14:   t = 32'h0000A2FA;
            5'd15:   t = 32'h0000517D;
            5'd16:   t = 32'h000028BE;
            5'd17:   t = 32'h0000145F;
            5'd18:   t = 32'h00000A30;
            5'd19:   t = 32'h00000518;
            5'd20:   t = 32'h0000028C;
            5'd21:   t = 32'h00000146;
            5'd22:   t = 32'h000000A3;
            5'd23:   t = 32'h00000051;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// ----- src/mocal_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mocal_front
// Accepts items, keeps the configuration and calibration state, and turns a
// measure item into a corrected, saturated reading for the queue.
// ----------------------------------------------------------------------------
module mocal_front
    import mocal_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IW-1:0]        cfg_index,
    input  wire logic [15:0]              cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               op,
    input  wire logic signed [15:0]       x_sample,
    input  wire logic signed [15:0]       y_sample,
    input  wire logic signed [15:0]       z_sample,
    input  wire q_status_t                q_status,
    output logic                          q_push,
    output q_entry_t                      q_entry
);

    logic signed [15:0] offset_x_reg, offset_y_reg, offset_z_reg;
    logic [14:0]        gate_reg;
    logic signed [15:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [15:0] max_x_reg, max_y_reg, max_z_reg;
    logic signed [15:0] learned_x_reg, learned_y_reg, learned_z_reg;
    logic               learned_valid_reg;

    logic signed [15:0] ox, oy, oz;
    logic signed [15:0] cx, cy, cz;
    logic               clip_x, clip_y, clip_z;
    logic               accept;
    op_t                op_code;
    logic signed [16:0] gate_pos, gate_neg;

    function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                   input logic signed [15:0] b,
                                                   output logic clip);
        logic signed [16:0] s;
        s = {a[15], a} + {b[15], b};
        clip = s[16] != s[15];
        if (!clip) begin
            return s[15:0];
        end
        return s[16] ? 16'sh8000 : 16'sh7fff;
    endfunction

    // minus the midpoint, truncated toward zero
    function automatic logic signed [15:0] centre_neg(input logic signed [15:0] mn,
                                                      input logic signed [15:0] mx);
        logic signed [16:0] s;
        logic signed [16:0] h;
        s = {mx[15], mx} + {mn[15], mn};
        h = (s + $signed({16'd0, s[16]})) >>> 1;
        return 16'(-h);
    endfunction

    function automatic logic lower(input logic signed [15:0] r,
                                   input logic signed [15:0] mn,
                                   input logic signed [16:0] gneg);
        return (r < mn) && ($signed({r[15], r}) > gneg);
    endfunction

    function automatic logic raise(input logic signed [15:0] r,
                                   input logic signed [15:0] mx,
                                   input logic signed [16:0] gpos);
        return (r > mx) && ($signed({r[15], r}) < gpos);
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_status.full;
    assign accept    = in_valid && in_ready;
    assign op_code   = op_t'(op);
    assign gate_pos  = {2'b00, gate_reg};
    assign gate_neg  = -gate_pos;

    assign ox = learned_valid_reg ? learned_x_reg : offset_x_reg;
    assign oy = learned_valid_reg ? learned_y_reg : offset_y_reg;
    assign oz = learned_valid_reg ? learned_z_reg : offset_z_reg;

    always_comb
    begin
        cx = sat_add(x_sample, ox, clip_x);
        cy = sat_add(y_sample, oy, clip_y);
        cz = sat_add(z_sample, oz, clip_z);
    end

    assign q_push        = accept;
    assign q_entry.meas  = op_code == OP_MEASURE;
    assign q_entry.sat   = clip_x || clip_y || clip_z;
    assign q_entry.cx    = cx;
    assign q_entry.cy    = cy;
    assign q_entry.cz    = cz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
            gate_reg     <= GATE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OFFSET_X: offset_x_reg <= cfg_data;
                CFG_OFFSET_Y: offset_y_reg <= cfg_data;
                CFG_OFFSET_Z: offset_z_reg <= cfg_data;
                CFG_GATE:     gate_reg     <= cfg_data[14:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg         <= '0;
            min_y_reg         <= '0;
            min_z_reg         <= '0;
            max_x_reg         <= '0;
            max_y_reg         <= '0;
            max_z_reg         <= '0;
            learned_x_reg     <= '0;
            learned_y_reg     <= '0;
            learned_z_reg     <= '0;
            learned_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            case (op_code)
                OP_CLEAR:
                begin
                    min_x_reg <= '0;
                    min_y_reg <= '0;
                    min_z_reg <= '0;
                    max_x_reg <= '0;
                    max_y_reg <= '0;
                    max_z_reg <= '0;
                end
                OP_CAL:
                begin
                    // raw reading, no offset applied
                    if (lower(x_sample, min_x_reg, gate_neg)) min_x_reg <= x_sample;
                    if (lower(y_sample, min_y_reg, gate_neg)) min_y_reg <= y_sample;
                    if (lower(z_sample, min_z_reg, gate_neg)) min_z_reg <= z_sample;
                    if (raise(x_sample, max_x_reg, gate_pos)) max_x_reg <= x_sample;
                    if (raise(y_sample, max_y_reg, gate_pos)) max_y_reg <= y_sample;
                    if (raise(z_sample, max_z_reg, gate_pos)) max_z_reg <= z_sample;
                end
                OP_FINISH:
                begin
                    learned_x_reg     <= centre_neg(min_x_reg, max_x_reg);
                    learned_y_reg     <= centre_neg(min_y_reg, max_y_reg);
                    learned_z_reg     <= centre_neg(min_z_reg, max_z_reg);
                    learned_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- src/mocal_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mocal_queue
// Short first-in first-out queue of corrected readings between the front
// and the heading engine.
// ----------------------------------------------------------------------------
module mocal_queue
    import mocal_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire q_entry_t  push_entry,
    input  wire logic      pop,
    output q_entry_t       head,
    output q_status_t      status
);

    q_entry_t         mem_reg [QDEPTH];
    logic [QAW-1:0]   wptr_reg, rptr_reg;
    logic [QAW:0]     cnt_reg;

    assign status.full  = cnt_reg == (QAW+1)'(QDEPTH);
    assign status.empty = cnt_reg == '0;
    assign head         = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/mocal_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mocal_back
// Pipelined vectoring rotation engine that finds the heading of a corrected
// reading, one rotation per stage, followed by the result register.
// ----------------------------------------------------------------------------
module mocal_back
    import mocal_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire q_entry_t      q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic signed [15:0] x_corrected,
    output logic signed [15:0] y_corrected,
    output logic signed [15:0] z_corrected,
    output logic signed [15:0] heading,
    output logic               saturated
);

    localparam int NS = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    typedef struct packed {
        logic               meas;
        logic               sat;
        logic               zero;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]        z;
    } stage_t;

    stage_t           st_reg  [NS+1];
    logic [NS:0]      vld_reg;
    logic [NS+1:0]    adv;
    stage_t           prep;
    logic signed [CW-1:0] xs0, ys0;
    logic [31:0]      zround;

    logic               out_valid_reg;
    logic signed [15:0] x_out_reg, y_out_reg, z_out_reg, h_out_reg;
    logic               sat_out_reg;

    // a stage moves when it is empty or the one after it moves
    assign adv[NS+1] = !out_valid_reg || out_ready;
    generate
        for (genvar k = 0; k <= NS; k++)
        begin : g_adv
            assign adv[k] = !vld_reg[k] || adv[k+1];
        end
    endgenerate

    assign q_pop = q_valid && adv[0];

    // scale by 256 and fold the left half plane onto the right
    assign xs0 = {{(CW-24){q_head.cx[15]}}, q_head.cx, 8'h00};
    assign ys0 = {{(CW-24){q_head.cy[15]}}, q_head.cy, 8'h00};

    always_comb
    begin
        prep.meas = q_head.meas;
        prep.sat  = q_head.sat;
        prep.zero = (q_head.cx == 16'sd0) && (q_head.cy == 16'sd0);
        prep.cx   = q_head.cx;
        prep.cy   = q_head.cy;
        prep.cz   = q_head.cz;
        if (q_head.cx[15])
        begin
            prep.x = -xs0;
            prep.y = -ys0;
            prep.z = 32'h80000000;
        end
        else
        begin
            prep.x = xs0;
            prep.y = ys0;
            prep.z = 32'h00000000;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            st_reg[0] <= prep;
        end
    end

    generate
        for (genvar k = 1; k <= NS; k++)
        begin : g_stage
            stage_t nxt;
            always_comb
            begin
                nxt = st_reg[k-1];
                if (!st_reg[k-1].y[CW-1])
                begin
                    nxt.x = st_reg[k-1].x + (st_reg[k-1].y >>> (k-1));
                    nxt.y = st_reg[k-1].y - (st_reg[k-1].x >>> (k-1));
                    nxt.z = st_reg[k-1].z + atan_entry(5'(k-1));
                end
                else
                begin
                    nxt.x = st_reg[k-1].x - (st_reg[k-1].y >>> (k-1));
                    nxt.y = st_reg[k-1].y + (st_reg[k-1].x >>> (k-1));
                    nxt.z = st_reg[k-1].z - atan_entry(5'(k-1));
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv[k])
                begin
                    st_reg[k] <= nxt;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k <= NS; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= (k == 0) ? q_valid : vld_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    // round half up to 16 bits, wrap at pi
    assign zround = st_reg[NS].z + 32'h00008000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv[NS+1])
        begin
            out_valid_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS+1])
        begin
            if (st_reg[NS].meas)
            begin
                x_out_reg   <= st_reg[NS].cx;
                y_out_reg   <= st_reg[NS].cy;
                z_out_reg   <= st_reg[NS].cz;
                h_out_reg   <= st_reg[NS].zero ? 16'sd0 : zround[31:16];
                sat_out_reg <= st_reg[NS].sat;
            end
            else
            begin
                x_out_reg   <= '0;
                y_out_reg   <= '0;
                z_out_reg   <= '0;
                h_out_reg   <= '0;
                sat_out_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign x_corrected = x_out_reg;
    assign y_corrected = y_out_reg;
    assign z_corrected = z_out_reg;
    assign heading     = h_out_reg;
    assign saturated   = sat_out_reg;

endmodule
`default_nettype wire

// ----- src/magnetometer_offset_calibration_heading.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// magnetometer_offset_calibration_heading
// Hard-iron offset calibration and heading for a three-axis magnetometer.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_ready is high and gives one
// result per item, in order. A measure item returns the reading plus the
// active offset (saturated to 16 bits, with a flag) and the heading atan2(y,
// x) as a 16-bit binary angle where 32768 is pi; clear, calibration and
// finish items update the min/max tracking and learned offsets and return an
// all-zero result. Calibration state changes as the item is accepted, so an
// item sees the effect of every earlier one. The heading comes from a fully
// pipelined rotation engine of CORDIC_STAGES stages; an item passes the
// queue, the input register, the rotation stages and the result register,
// and the four-deep queue absorbs backpressure. Configuration writes are
// always ready and take effect at once; write them only while idle.
module magnetometer_offset_calibration_heading
    import mocal_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CFG_IW-1:0]  cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         op,
    input  wire logic signed [15:0] x_sample,
    input  wire logic signed [15:0] y_sample,
    input  wire logic signed [15:0] z_sample,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      x_corrected,
    output logic signed [15:0]      y_corrected,
    output logic signed [15:0]      z_corrected,
    output logic signed [15:0]      heading,
    output logic                    saturated
);

    q_status_t q_status;
    q_entry_t  q_entry;
    q_entry_t  q_head;
    logic      q_push;
    logic      q_pop;

    mocal_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .x_sample  (x_sample),
        .y_sample  (y_sample),
        .z_sample  (z_sample),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    mocal_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    mocal_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (!q_status.empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .x_corrected (x_corrected),
        .y_corrected (y_corrected),
        .z_corrected (z_corrected),
        .heading     (heading),
        .saturated   (saturated)
    );

    // queue never written when full nor read when empty
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue read while empty");

    // a nonzero heading needs a nonzero vector
    a_heading_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && heading != 16'sd0) |->
            (x_corrected != 16'sd0 || y_corrected != 16'sd0))
        else $error("heading given for a zero vector");

endmodule
`default_nettype wire
